@@ hdl/lpht_pkg.sv @@
// Shared types, codes and helpers for the linear-probe hash table.
// Depends on nothing; the top level, hash unit and slot storage import it.
package lpht_pkg;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int LEN_W    = 4;
    localparam int HASH_W   = 32;
    localparam int FILL_W   = 10;
    localparam int LIVE_W   = 11;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 2;

    localparam logic [HASH_W-1:0] FNV_OFFSET = 32'h811C9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME  = 32'h01000193;
    localparam logic [FILL_W-1:0] FILL_RESET = 10'd716;

    localparam logic [OP_W-1:0] OP_SET = 2'd0;
    localparam logic [OP_W-1:0] OP_GET = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_len;
        logic [VAL_W-1:0]  value;
        logic [LEN_W-1:0]  value_len;
    } t_slot;

    // Keeps the low len bytes of a 64-bit word; len of 8 or more keeps all.
    function automatic logic [63:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

@@ hdl/linear_probe_hash_table_top.sv @@
// Top level of the linear-probe hash table: handshakes, probe sequencer, output register.
// Depends on lpht_pkg, lpht_hash and lpht_store.
//
// Usage. Each transfer on the slave stream is one command: tuser carries the
// op (set, get, delete, no-op), tdata the key, key length, value and value length.
// Each command gives exactly one transfer on the master stream with the status
// in tuser and the found value, its length and the live entry count in tdata.
// The fill limit is to be written by the user through i_cfg_we / i_cfg_wdata
// only while idle; the block itself does not enforce it. Commands are handled
// one at a time. A command occupies the sequencer while the FNV-1a unit hashes
// its key byte by byte, then for each slot visited while the probe reads the
// slot memories through their registered read and evaluates the registered
// data. A set that does not find its key takes one more state for the insert
// decision and write. The probe length is set by the cluster around the home
// slot and is at most TABLE_DEPTH slots.
// After reset the mark memory is cleared one slot per cycle, so
// s_axis_tready stays low until that pass ends; fill-limit writes are
// taken during that pass. The result sits in an output register: while the
// receiver stalls, the next command is still accepted and processed, and
// only its own result waits until the register is free.
module linear_probe_hash_table_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [9:0]   i_cfg_wdata,    // fill_limit
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // key[63:0], key_len[67:64], value[131:68],
                                         // value_len[135:132]
    input  logic [1:0]   s_axis_tuser,   // op[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // found_value[63:0], found_value_len[67:64],
                                         // entry_count[77:68], zero[79:78]
    output logic [1:0]   m_axis_tuser    // status[1:0]
);
    import lpht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Unpack the slave payload and clean it up: saturate lengths, zero unused bytes.
    logic [OP_W-1:0]  in_op;
    logic [LEN_W-1:0] in_kl, in_vl;
    logic [KEY_W-1:0] in_key;
    logic [VAL_W-1:0] in_val;
    logic             in_accept;

    assign in_op  = s_axis_tuser;
    assign in_kl  = (s_axis_tdata[67:64] > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                              : s_axis_tdata[67:64];
    assign in_vl  = (s_axis_tdata[135:132] > LEN_W'(VALUE_BYTES)) ? LEN_W'(VALUE_BYTES)
                                                                  : s_axis_tdata[135:132];
    assign in_key = s_axis_tdata[63:0] & byte_mask(in_kl);
    assign in_val = s_axis_tdata[131:68] & byte_mask(in_vl);

    logic [2:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [KEY_W-1:0]    r_key;
    logic [LEN_W-1:0]    r_kl, r_vl;
    logic [VAL_W-1:0]    r_val;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [AW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_have_tomb, n_have_tomb, r_have_empty, n_have_empty;
    logic [AW-1:0]       r_tomb, n_tomb, r_empty, n_empty;
    logic [LIVE_W-1:0]   r_live, n_live;
    logic [FILL_W-1:0]   r_fill;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]    r_rval, n_rval;
    logic [LEN_W-1:0]    r_rlen, n_rlen;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VAL_W-1:0]    r_out_val;
    logic [LEN_W-1:0]    r_out_len;
    logic [FILL_W-1:0]   r_out_count;

    logic              hash_done;
    logic [HASH_W-1:0] hash_val;
    logic              mark_we, slot_we;
    logic [AW-1:0]     mark_waddr, slot_waddr;
    logic [MARK_W-1:0] mark_wdata, rd_mark;
    t_slot             slot_wdata, rd_slot;
    logic              clearing;
    logic              match, last_probe, out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    lpht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept && in_op != OP_NOP),
        .i_key   (in_key),
        .i_len   (in_kl),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    lpht_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_addr    (r_pos),
        .i_mark_we    (mark_we),
        .i_mark_waddr (mark_waddr),
        .i_mark_wdata (mark_wdata),
        .i_slot_we    (slot_we),
        .i_slot_waddr (slot_waddr),
        .i_slot_wdata (slot_wdata),
        .o_mark       (rd_mark),
        .o_slot       (rd_slot),
        .o_clearing   (clearing)
    );

    // A slot holds the key when it is live and hash, length and bytes agree.
    assign match = (rd_mark == MARK_LIVE) && (rd_slot.hash == r_hash) &&
                   (rd_slot.key_len == r_kl) && (rd_slot.key == r_key);
    assign last_probe = (r_cnt == CW'(TABLE_DEPTH - 1));
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Writes are issued only in S_EVAL and S_FIN, and the next read of the
    // memories comes only after the next command's S_HASH state, so no forwarding is needed.
    assign slot_wdata = '{hash: r_hash, key: r_key, key_len: r_kl,
                          value: r_val, value_len: r_vl};

    always_comb begin
        n_state      = r_state;
        n_hash       = r_hash;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_have_tomb  = r_have_tomb;
        n_have_empty = r_have_empty;
        n_tomb       = r_tomb;
        n_empty      = r_empty;
        n_live       = r_live;
        n_status     = r_status;
        n_rval       = r_rval;
        n_rlen       = r_rlen;
        mark_we      = 1'b0;
        mark_waddr   = r_pos;
        mark_wdata   = MARK_LIVE;
        slot_we      = 1'b0;
        slot_waddr   = r_pos;

        case (r_state)
            S_CLEAR: begin
                if (!clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_status     = ST_OK;
                    n_rval       = '0;
                    n_rlen       = '0;
                    n_have_tomb  = 1'b0;
                    n_have_empty = 1'b0;
                    n_state      = (in_op == OP_NOP) ? S_DONE : S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_hash  = hash_val;
                    n_pos   = hash_val[AW-1:0];
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_op == OP_SET) begin
                    if (rd_mark == MARK_EMPTY) begin
                        n_have_empty = 1'b1;
                        n_empty      = r_pos;
                        n_state      = S_FIN;
                    end else if (match) begin
                        // Update in place; the key fields written back are unchanged.
                        slot_we  = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        if (rd_mark == MARK_TOMB && !r_have_tomb) begin
                            n_have_tomb = 1'b1;
                            n_tomb      = r_pos;
                        end
                        if (last_probe) begin
                            n_state = S_FIN;
                        end else begin
                            n_pos   = r_pos + 1'b1;
                            n_cnt   = r_cnt + 1'b1;
                            n_state = S_READ;
                        end
                    end
                end else begin
                    if (rd_mark == MARK_EMPTY) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else if (match) begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                        if (r_op == OP_GET) begin
                            n_rval = rd_slot.value;
                            n_rlen = rd_slot.value_len;
                        end else begin
                            mark_we    = 1'b1;
                            mark_wdata = MARK_TOMB;
                            if (r_live != '0) begin
                                n_live = r_live - 1'b1;
                            end
                        end
                    end else if (last_probe) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_FIN: begin
                // New key: first tombstone passed, else empty slot; full at limit or none.
                n_state = S_DONE;
                if (r_live >= {1'b0, r_fill} || (!r_have_tomb && !r_have_empty)) begin
                    n_status = ST_FULL;
                end else begin
                    mark_we    = 1'b1;
                    mark_waddr = r_have_tomb ? r_tomb : r_empty;
                    slot_we    = 1'b1;
                    slot_waddr = mark_waddr;
                    n_live     = r_live + 1'b1;
                    n_status   = ST_OK;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_live      <= '0;
            r_fill      <= FILL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_fill <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= in_op;
            r_key <= in_key;
            r_kl  <= in_kl;
            r_val <= in_val;
            r_vl  <= in_vl;
        end
        r_hash       <= n_hash;
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_have_tomb  <= n_have_tomb;
        r_have_empty <= n_have_empty;
        r_tomb       <= n_tomb;
        r_empty      <= n_empty;
        r_status     <= n_status;
        r_rval       <= n_rval;
        r_rlen       <= n_rlen;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_val    <= r_rval;
            r_out_len    <= r_rlen;
            r_out_count  <= r_live[FILL_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_count, r_out_len, r_out_val};
endmodule

@@ hdl/lpht_hash.sv @@
// Byte-serial 32-bit FNV-1a unit: one key byte per cycle.
// Depends on lpht_pkg.
module lpht_hash (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpht_pkg::KEY_W-1:0]  i_key,
    input  logic [lpht_pkg::LEN_W-1:0]  i_len,
    output logic                        o_done,
    output logic [lpht_pkg::HASH_W-1:0] o_hash
);
    import lpht_pkg::*;

    logic              r_busy;
    logic [HASH_W-1:0] r_h;
    logic [KEY_W-1:0]  r_k;
    logic [LEN_W-1:0]  r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h    <= FNV_OFFSET;
            r_k    <= i_key;
            r_left <= i_len;
        end else if (r_busy && r_left != '0) begin
            r_h    <= (r_h ^ {24'd0, r_k[7:0]}) * FNV_PRIME;
            r_k    <= r_k >> 8;
            r_left <= r_left - 1'b1;
        end
    end

    assign o_done = r_busy && (r_left == '0);
    assign o_hash = r_h;
endmodule

@@ hdl/lpht_store.sv @@
// Slot storage: a mark memory with a clearing pass after reset and a payload memory.
// Depends on lpht_pkg. Both memories have one write port and a registered read.
module lpht_store #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     i_rd_addr,
    input  logic                               i_mark_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     i_mark_waddr,
    input  logic [lpht_pkg::MARK_W-1:0]        i_mark_wdata,
    input  logic                               i_slot_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     i_slot_waddr,
    input  lpht_pkg::t_slot                    i_slot_wdata,
    output logic [lpht_pkg::MARK_W-1:0]        o_mark,
    output lpht_pkg::t_slot                    o_slot,
    output logic                               o_clearing
);
    import lpht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [MARK_W-1:0] mark_mem [TABLE_DEPTH];
    t_slot             slot_mem [TABLE_DEPTH];
    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mark_mem[r_clr_addr] <= MARK_EMPTY;
        end else if (i_mark_we) begin
            mark_mem[i_mark_waddr] <= i_mark_wdata;
        end
        o_mark <= mark_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_slot_we) begin
            slot_mem[i_slot_waddr] <= i_slot_wdata;
        end
        o_slot <= slot_mem[i_rd_addr];
    end

    assign o_clearing = r_clearing;
endmodule

@@ hdl/lpht_checker.sv @@
// Port-level checks for the linear-probe hash table, bound to the top level.
// Depends on linear_probe_hash_table_top.
module lpht_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    // A result that is not taken holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Status never carries the unused code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("invalid status code");

    // Only a successful command may return a value.
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata[67:0] == 68'd0)
        else $error("value returned on a failed command");

    // Commands are taken one at a time.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken back to back");
endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
